@@ src/bsd_pkg.sv @@
// ----------------------------------------------------------------------------
// bsd_pkg
// shared types and constants for the byte stream digest block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsd_pkg;

  localparam int DIGEST_BYTES = 32;
  localparam int IDX_W        = $clog2(DIGEST_BYTES);

  localparam logic [7:0]       INIT_XOR    = 8'h7F;
  localparam logic [31:0]      GOLDEN_MULT = 32'h9E3779B9;
  localparam logic [IDX_W-1:0] MIX_OFFSET  = IDX_W'(17);
  localparam logic [IDX_W-1:0] SHIFT_SLOT  = IDX_W'(5);
  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(DIGEST_BYTES - 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } bsd_in_t;

  typedef struct packed {
    logic [7:0]       digest_byte;
    logic [IDX_W-1:0] digest_index;
    logic             digest_last;
  } bsd_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULT,
    S_ALIGN,
    S_MIX,
    S_EMIT
  } bsd_state_t;

  typedef enum logic [2:0] {
    DP_HOLD,
    DP_ABSORB,
    DP_ALIGN,
    DP_MULT,
    DP_MIX,
    DP_EMIT
  } bsd_op_t;

  typedef struct packed {
    bsd_op_t op;
    logic    restart;
  } bsd_cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic cnt_last;
    logic out_free;
  } bsd_sts_t;

endpackage

@@ src/byte_stream_digest_32.sv @@
// ----------------------------------------------------------------------------
// byte_stream_digest_32
// message byte: one per cycle back to back while the input is not stalled
// final item: stalls input until the last digest byte is loaded for output (32
//   multiply steps on the one multiplier, align steps, 32 mix and 32 emit steps)
// digest bytes leave one per cycle from the output register unless stalled
// reset: store back to 0x7F xor index, position zero, no digest pending
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_stream_digest_32 (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bsd_pkg::bsd_in_t  item,
  output logic              digest_valid,
  input  logic              digest_stall,
  output bsd_pkg::bsd_out_t digest
);
  import bsd_pkg::*;

  bsd_cmd_t cmd;
  bsd_sts_t sts;

  bsd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  bsd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

endmodule

@@ src/bsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsd_ctrl
// sequencer: absorb, multiply, align, mix and emit phases of the digest
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  bsd_pkg::bsd_in_t  item,
  output logic              item_stall,
  input  bsd_pkg::bsd_sts_t sts,
  output bsd_pkg::bsd_cmd_t cmd
);
  import bsd_pkg::*;

  bsd_state_t state;
  bsd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid && item.end_of_message) begin
          state_next = S_MULT;
        end
      end
      S_MULT: begin
        if (sts.cnt_last) begin
          state_next = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (sts.pos_zero) begin
          state_next = S_MIX;
        end
      end
      S_MIX: begin
        if (sts.cnt_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free && sts.cnt_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op      = DP_HOLD;
    cmd.restart = 1'b0;
    item_stall  = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (item_valid && item.has_byte) begin
          cmd.op = DP_ABSORB;
        end
      end
      S_MULT: cmd.op = DP_MULT;
      S_ALIGN: begin
        // rotate until logical slot 0 sits at the head
        if (!sts.pos_zero) begin
          cmd.op = DP_ALIGN;
        end
      end
      S_MIX: cmd.op = DP_MIX;
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op      = DP_EMIT;
          cmd.restart = sts.cnt_last;
        end
      end
      default: cmd.op = DP_HOLD;
    endcase
  end

endmodule

@@ src/bsd_datapath.sv @@
// ----------------------------------------------------------------------------
// bsd_datapath
// rotating 32-byte store, shared multiplier, counters and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsd_datapath (
  input  logic              clk,
  input  logic              rst,
  input  bsd_pkg::bsd_in_t  item,
  input  bsd_pkg::bsd_cmd_t cmd,
  output bsd_pkg::bsd_sts_t sts,
  output logic              digest_valid,
  input  logic              digest_stall,
  output bsd_pkg::bsd_out_t digest
);
  import bsd_pkg::*;

  // the store is kept rotated: the slot being worked on always sits at index 0
  logic [7:0]       store      [DIGEST_BYTES];
  logic [7:0]       store_next [DIGEST_BYTES];
  logic [7:0]       upd        [DIGEST_BYTES];
  logic             rotate;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] cnt;
  logic [31:0]      prod;
  logic [7:0]       b;

  assign b    = item.data_byte;
  assign prod = {24'b0, store[0]} * GOLDEN_MULT;

  always_comb begin
    for (int i = 0; i < DIGEST_BYTES; i++) begin
      upd[i] = store[i];
    end
    rotate = 1'b0;
    case (cmd.op)
      DP_ABSORB: begin
        upd[0]          = store[0] ^ b;
        upd[1]          = store[1] + b;
        upd[SHIFT_SLOT] = store[SHIFT_SLOT] ^ {b[6:0], 1'b0};
        rotate          = 1'b1;
      end
      DP_ALIGN: rotate = 1'b1;
      DP_MULT: begin
        upd[0] = prod[31:24];
        rotate = 1'b1;
      end
      DP_MIX: begin
        upd[0] = store[0] ^ store[MIX_OFFSET];
        rotate = 1'b1;
      end
      DP_EMIT: rotate = 1'b1;
      default: rotate = 1'b0;
    endcase
    for (int i = 0; i < DIGEST_BYTES; i++) begin
      if (cmd.restart) begin
        store_next[i] = INIT_XOR ^ 8'(i);
      end else if (rotate) begin
        store_next[i] = upd[IDX_W'(i + 1)];
      end else begin
        store_next[i] = upd[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGEST_BYTES; i++) begin
        store[i] <= INIT_XOR ^ 8'(i);
      end
    end else begin
      for (int i = 0; i < DIGEST_BYTES; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      cnt <= '0;
    end else begin
      if (cmd.restart) begin
        pos <= '0;
      end else if (cmd.op == DP_ABSORB || cmd.op == DP_ALIGN) begin
        pos <= pos + 1'b1;
      end
      // wraps to zero at the end of every 32-step phase
      if (cmd.op == DP_MULT || cmd.op == DP_MIX || cmd.op == DP_EMIT) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign sts.pos_zero = (pos == '0);
  assign sts.cnt_last = (cnt == LAST_IDX);
  assign sts.out_free = !digest_valid || !digest_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
    end else if (cmd.op == DP_EMIT) begin
      digest_valid <= 1'b1;
    end else if (!digest_stall) begin
      digest_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT) begin
      digest.digest_byte  <= store[0];
      digest.digest_index <= cnt;
      digest.digest_last  <= (cnt == LAST_IDX);
    end
  end

endmodule

@@ src/bsd_checker.sv @@
// ----------------------------------------------------------------------------
// bsd_checker
// port-level checks on the digest block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsd_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input bsd_pkg::bsd_in_t  item,
  input logic              digest_valid,
  input logic              digest_stall,
  input bsd_pkg::bsd_out_t digest
);
  import bsd_pkg::*;

  // nothing pending and input open straight after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !digest_valid && !item_stall)
    else $error("block not idle after reset");

  // last flag marks index 31 only
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (digest.digest_last == (digest.digest_index == LAST_IDX)))
    else $error("digest_last does not match digest_index");

  // a finishing transaction closes the input until the digest is out
  a_finish_stalls: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.end_of_message |=> item_stall)
    else $error("input open after finishing transaction");

  // while digest bytes before the last are pending no new item is taken
  a_emit_blocks: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest.digest_last |-> item_stall)
    else $error("input open during digest output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_stall |=> digest_valid && $stable(digest))
    else $error("stalled digest transaction changed");

endmodule

bind byte_stream_digest_32 bsd_checker u_bsd_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .digest_valid (digest_valid),
  .digest_stall (digest_stall),
  .digest       (digest)
);
